// ===== design/spsc_pkg.sv =====
// Types and constants shared by the separator-line clip pipeline.
package spsc_pkg;

   localparam int unsigned NumLines     = 4;
   localparam int unsigned SqrtSteps    = 32;
   localparam int unsigned LineDivSteps = 30;
   localparam int unsigned CutDivSteps  = 32;
   localparam logic [15:0] EpsReset     = 16'd6554;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
   } seg_type;

   typedef struct packed {
      logic               use_line;
      logic               vert;
      logic               horz;
      logic signed [31:0] hx;
      logic signed [31:0] hy;
      logic signed [63:0] off;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
   } line_type;

   typedef struct packed {
      logic                         vis;
      seg_type                      seg;
      line_type [NumLines-1:0]      lines;
   } item_type;

   typedef struct packed {
      logic               ok;
      logic               negx;
      logic               negy;
      logic               vert;
      logic               horz;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] qx;
      logic signed [31:0] qy;
   } geo_type;

   typedef struct packed {
      logic cut;
      logic at0;
      logic a1z;
   } cut_type;

endpackage

// ===== design/separator_plane_segment_clip_core.sv =====
// Top level of the separator-line clip pipeline with its epsilon register.
// Each item passes through line setup (32-step square root, 30-step normal
// division), then through each of the four clip stages (32-step cut fraction
// division), and then through the output register.
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Reset clears all valid bits and sets epsilon to 6554.
module separator_plane_segment_clip_core
   import spsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_src_ax,
   input  logic signed [31:0] req_src_ay,
   input  logic signed [31:0] req_src_bx,
   input  logic signed [31:0] req_src_by,
   input  logic signed [31:0] req_pass_ax,
   input  logic signed [31:0] req_pass_ay,
   input  logic signed [31:0] req_pass_bx,
   input  logic signed [31:0] req_pass_by,
   input  logic signed [31:0] req_tgt_ax,
   input  logic signed [31:0] req_tgt_ay,
   input  logic signed [31:0] req_tgt_bx,
   input  logic signed [31:0] req_tgt_by,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_visible,
   output logic signed [31:0] rsp_out_ax,
   output logic signed [31:0] rsp_out_ay,
   output logic signed [31:0] rsp_out_bx,
   output logic signed [31:0] rsp_out_by,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_epsilon
);

   logic [15:0] eps_ff;
   logic        adv;
   logic        rsp_valid_ff;

   assign csr_ready = 1'b1;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EpsReset;
      end else if (csr_valid) begin
         eps_ff <= csr_epsilon;
      end
   end

   logic signed [31:0] sx [0:1];
   logic signed [31:0] sy [0:1];
   logic signed [31:0] px [0:1];
   logic signed [31:0] py [0:1];
   seg_type            tgt;

   assign sx[0] = req_src_ax;
   assign sy[0] = req_src_ay;
   assign sx[1] = req_src_bx;
   assign sy[1] = req_src_by;
   assign px[0] = req_pass_ax;
   assign py[0] = req_pass_ay;
   assign px[1] = req_pass_bx;
   assign py[1] = req_pass_by;

   always_comb begin
      tgt.ax = req_tgt_ax;
      tgt.ay = req_tgt_ay;
      tgt.bx = req_tgt_bx;
      tgt.by = req_tgt_by;
   end

   logic     lv   [0:NumLines-1];
   line_type ll   [0:NumLines-1];
   seg_type  lseg [0:NumLines-1];

   for (genvar k = 0; k < NumLines; k++) begin : g_line
      localparam bit SI = (k >= 2);
      localparam bit PJ = (k % 2 == 1);
      spsc_line u_line (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .eps       (eps_ff),
         .in_valid  (req_valid),
         .s_x       (sx[SI]),
         .s_y       (sy[SI]),
         .p_x       (px[PJ]),
         .p_y       (py[PJ]),
         .o_x       (sx[!SI]),
         .o_y       (sy[!SI]),
         .q_x       (px[!PJ]),
         .q_y       (py[!PJ]),
         .in_seg    (tgt),
         .out_valid (lv[k]),
         .out_line  (ll[k]),
         .out_seg   (lseg[k])
      );
   end

   logic     cv [0:NumLines];
   item_type ci [0:NumLines];

   assign cv[0] = lv[0];

   always_comb begin
      ci[0].vis = 1'b1;
      ci[0].seg = lseg[0];
      for (int k = 0; k < NumLines; k++) begin
         ci[0].lines[k] = ll[k];
      end
   end

   for (genvar k = 0; k < NumLines; k++) begin : g_clip
      spsc_clip u_clip (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .eps       (eps_ff),
         .in_valid  (cv[k]),
         .in_item   (ci[k]),
         .out_valid (cv[k+1]),
         .out_item  (ci[k+1])
      );
   end

   logic               vis_ff;
   logic signed [31:0] ax_ff, ay_ff, bx_ff, by_ff;
   item_type           fin;

   assign fin = ci[NumLines];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cv[NumLines];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vis_ff <= fin.vis;
         ax_ff  <= fin.vis ? fin.seg.ax : 32'sd0;
         ay_ff  <= fin.vis ? fin.seg.ay : 32'sd0;
         bx_ff  <= fin.vis ? fin.seg.bx : 32'sd0;
         by_ff  <= fin.vis ? fin.seg.by : 32'sd0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = vis_ff;
   assign rsp_out_ax  = ax_ff;
   assign rsp_out_ay  = ay_ff;
   assign rsp_out_bx  = bx_ff;
   assign rsp_out_by  = by_ff;

endmodule

// ===== design/spsc_sqrt_cell.sv =====
// One digit step of the integer square root chain.
module spsc_sqrt_cell
   import spsc_pkg::*;
#(
   parameter int unsigned K  = 0,
   parameter int unsigned PW = 1
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [63:0]   in_s,
   input  logic [63:0]   in_r,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [63:0]   out_s,
   output logic [63:0]   out_r,
   output logic [PW-1:0] out_pay
);

   localparam logic [63:0] Bit = 64'd1 << (62 - 2 * K);

   logic          valid_ff;
   logic [63:0]   s_ff, s_in, r_ff, r_in, trial;
   logic [PW-1:0] pay_ff;
   logic          ge;

   assign trial = in_r + Bit;
   assign ge    = in_s >= trial;
   assign s_in  = ge ? in_s - trial : in_s;
   assign r_in  = ge ? (in_r >> 1) + Bit : in_r >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff   <= s_in;
         r_ff   <= r_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_s     = s_ff;
   assign out_r     = r_ff;
   assign out_pay   = pay_ff;

endmodule

// ===== design/spsc_div_cell.sv =====
// One quotient bit step of a restoring divider chain.
module spsc_div_cell
   import spsc_pkg::*;
#(
   parameter int unsigned W  = 32,
   parameter int unsigned QW = 31,
   parameter int unsigned PW = 1
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [W-1:0]  in_rem,
   input  logic [W-1:0]  in_div,
   input  logic [QW-1:0] in_q,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [W-1:0]  out_rem,
   output logic [W-1:0]  out_div,
   output logic [QW-1:0] out_q,
   output logic [PW-1:0] out_pay
);

   logic          valid_ff;
   logic [W-1:0]  rem_ff, rem_in, div_ff;
   logic [QW-1:0] q_ff, q_in;
   logic [PW-1:0] pay_ff;
   logic [W:0]    rem2, diff;
   logic          ge;

   assign rem2   = {in_rem, 1'b0};
   assign diff   = rem2 - {1'b0, in_div};
   assign ge     = rem2 >= {1'b0, in_div};
   assign rem_in = ge ? diff[W-1:0] : rem2[W-1:0];
   assign q_in   = {in_q[QW-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         div_ff <= in_div;
         q_ff   <= q_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_q     = q_ff;
   assign out_pay   = pay_ff;

endmodule

// ===== design/spsc_line.sv =====
// Builds one normalized, oriented separating line from a source and a pass point.
module spsc_line
   import spsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [15:0]        eps,
   input  logic               in_valid,
   input  logic signed [31:0] s_x,
   input  logic signed [31:0] s_y,
   input  logic signed [31:0] p_x,
   input  logic signed [31:0] p_y,
   input  logic signed [31:0] o_x,
   input  logic signed [31:0] o_y,
   input  logic signed [31:0] q_x,
   input  logic signed [31:0] q_y,
   input  seg_type            in_seg,
   output logic               out_valid,
   output line_type           out_line,
   output seg_type            out_seg
);

   localparam int unsigned GW  = $bits(geo_type);
   localparam int unsigned SW  = $bits(seg_type);
   localparam int unsigned SPW = GW + 62 + SW;

   logic signed [32:0] nx, ny;
   logic [32:0]        ax, ay;
   logic [31:0]        sqx, sqy;
   logic               low_mag, short, ok;
   geo_type            geo0_in;

   assign nx      = 33'(s_y) - 33'(p_y);
   assign ny      = 33'(p_x) - 33'(s_x);
   assign ax      = nx[32] ? 33'(-nx) : 33'(nx);
   assign ay      = ny[32] ? 33'(-ny) : 33'(ny);
   assign sqx     = ax[15:0] * ax[15:0];
   assign sqy     = ay[15:0] * ay[15:0];
   assign low_mag = (ax[32:16] == 17'd0) && (ay[32:16] == 17'd0);
   assign short   = low_mag && (({1'b0, sqx} + {1'b0, sqy}) < {1'b0, eps, 16'd0});
   assign ok      = ((ax != 33'd0) || (ay != 33'd0)) && !short;

   always_comb begin
      geo0_in.ok   = ok;
      geo0_in.negx = nx[32];
      geo0_in.negy = ny[32];
      geo0_in.vert = (ny == 33'sd0);
      geo0_in.horz = (nx == 33'sd0);
      geo0_in.px   = p_x;
      geo0_in.py   = p_y;
      geo0_in.ox   = o_x;
      geo0_in.oy   = o_y;
      geo0_in.qx   = q_x;
      geo0_in.qy   = q_y;
   end

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   geo_type geo0_ff, geo1_ff, geo2_ff, geo3_ff;
   seg_type seg0_ff, seg1_ff, seg2_ff, seg3_ff;
   logic [32:0] ax0_ff, ay0_ff, m1;
   logic [30:0] ax1_ff, ay1_ff, ax1_in, ay1_in, ax2_ff, ay2_ff, ax3_ff, ay3_ff;
   logic [61:0] sqx2_ff, sqy2_ff;
   logic [62:0] sum3_ff;
   logic [4:0]  msb, lsh;

   assign m1 = (ax0_ff > ay0_ff) ? ax0_ff : ay0_ff;

   always_comb begin
      msb = 5'd0;
      for (int b = 0; b < 31; b++) begin
         if (m1[b]) begin
            msb = 5'(b);
         end
      end
   end

   assign lsh = 5'd30 - msb;

   always_comb begin
      if (m1[32]) begin
         ax1_in = ax0_ff[32:2];
         ay1_in = ay0_ff[32:2];
      end else if (m1[31]) begin
         ax1_in = ax0_ff[31:1];
         ay1_in = ay0_ff[31:1];
      end else begin
         ax1_in = ax0_ff[30:0] << lsh;
         ay1_in = ay0_ff[30:0] << lsh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo0_ff <= geo0_in;
         seg0_ff <= in_seg;
         ax0_ff  <= ax;
         ay0_ff  <= ay;
         geo1_ff <= geo0_ff;
         seg1_ff <= seg0_ff;
         ax1_ff  <= ax1_in;
         ay1_ff  <= ay1_in;
         geo2_ff <= geo1_ff;
         seg2_ff <= seg1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         sqx2_ff <= ax1_ff * ax1_ff;
         sqy2_ff <= ay1_ff * ay1_ff;
         geo3_ff <= geo2_ff;
         seg3_ff <= seg2_ff;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         sum3_ff <= {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      end
   end

   logic           sq_v   [0:SqrtSteps];
   logic [63:0]    sq_s   [0:SqrtSteps];
   logic [63:0]    sq_r   [0:SqrtSteps];
   logic [SPW-1:0] sq_pay [0:SqrtSteps];

   assign sq_v[0]   = v3_ff;
   assign sq_s[0]   = {1'b0, sum3_ff};
   assign sq_r[0]   = 64'd0;
   assign sq_pay[0] = {geo3_ff, ax3_ff, ay3_ff, seg3_ff};

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      spsc_sqrt_cell #(.K(k), .PW(SPW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_v[k]),
         .in_s      (sq_s[k]),
         .in_r      (sq_r[k]),
         .in_pay    (sq_pay[k]),
         .out_valid (sq_v[k+1]),
         .out_s     (sq_s[k+1]),
         .out_r     (sq_r[k+1]),
         .out_pay   (sq_pay[k+1])
      );
   end

   geo_type     geo4;
   seg_type     seg4;
   logic [30:0] ax4, ay4;
   logic [31:0] r4;
   logic        qx30, qy30;

   assign {geo4, ax4, ay4, seg4} = sq_pay[SqrtSteps];
   assign r4   = sq_r[SqrtSteps][31:0];
   assign qx30 = ({1'b0, ax4} == r4);
   assign qy30 = ({1'b0, ay4} == r4);

   logic          dx_v   [0:LineDivSteps];
   logic [31:0]   dx_rem [0:LineDivSteps];
   logic [31:0]   dx_div [0:LineDivSteps];
   logic [30:0]   dx_q   [0:LineDivSteps];
   logic [GW-1:0] dx_pay [0:LineDivSteps];
   logic          dy_v   [0:LineDivSteps];
   logic [31:0]   dy_rem [0:LineDivSteps];
   logic [31:0]   dy_div [0:LineDivSteps];
   logic [30:0]   dy_q   [0:LineDivSteps];
   logic [SW-1:0] dy_pay [0:LineDivSteps];

   assign dx_v[0]   = sq_v[SqrtSteps];
   assign dx_rem[0] = qx30 ? 32'd0 : {1'b0, ax4};
   assign dx_div[0] = r4;
   assign dx_q[0]   = {30'd0, qx30};
   assign dx_pay[0] = geo4;
   assign dy_v[0]   = sq_v[SqrtSteps];
   assign dy_rem[0] = qy30 ? 32'd0 : {1'b0, ay4};
   assign dy_div[0] = r4;
   assign dy_q[0]   = {30'd0, qy30};
   assign dy_pay[0] = seg4;

   for (genvar k = 0; k < LineDivSteps; k++) begin : g_div
      spsc_div_cell #(.W(32), .QW(31), .PW(GW)) u_cell_x (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dx_v[k]),
         .in_rem    (dx_rem[k]),
         .in_div    (dx_div[k]),
         .in_q      (dx_q[k]),
         .in_pay    (dx_pay[k]),
         .out_valid (dx_v[k+1]),
         .out_rem   (dx_rem[k+1]),
         .out_div   (dx_div[k+1]),
         .out_q     (dx_q[k+1]),
         .out_pay   (dx_pay[k+1])
      );
      spsc_div_cell #(.W(32), .QW(31), .PW(SW)) u_cell_y (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dy_v[k]),
         .in_rem    (dy_rem[k]),
         .in_div    (dy_div[k]),
         .in_q      (dy_q[k]),
         .in_pay    (dy_pay[k]),
         .out_valid (dy_v[k+1]),
         .out_rem   (dy_rem[k+1]),
         .out_div   (dy_div[k+1]),
         .out_q     (dy_q[k+1]),
         .out_pay   (dy_pay[k+1])
      );
   end

   geo_type            geo5;
   logic signed [31:0] hx5_in, hy5_in;

   assign geo5   = dx_pay[LineDivSteps];
   assign hx5_in = geo5.negx ? -$signed({1'b0, dx_q[LineDivSteps]})
                             : $signed({1'b0, dx_q[LineDivSteps]});
   assign hy5_in = geo5.negy ? -$signed({1'b0, dy_q[LineDivSteps]})
                             : $signed({1'b0, dy_q[LineDivSteps]});

   logic v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   geo_type geo5_ff, geo6_ff, geo7_ff, geo8_ff;
   seg_type seg5_ff, seg6_ff, seg7_ff, seg8_ff, seg9_ff;
   logic signed [31:0] hx5_ff, hy5_ff, hx6_ff, hy6_ff, hx7_ff, hy7_ff, hx8_ff, hy8_ff;
   logic signed [63:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [63:0] p1_in, p2_in, p3_in, p4_in, p5_in, p6_in;
   logic signed [63:0] off7_ff, sa7_ff, pa7_ff, off8_ff, ds8_ff, dp8_ff;
   line_type line9_ff, line9_in;

   assign p1_in = geo5_ff.px * hx5_ff;
   assign p2_in = geo5_ff.py * hy5_ff;
   assign p3_in = geo5_ff.ox * hx5_ff;
   assign p4_in = geo5_ff.oy * hy5_ff;
   assign p5_in = geo5_ff.qx * hx5_ff;
   assign p6_in = geo5_ff.qy * hy5_ff;

   logic signed [63:0] e, dpo;
   logic               flip, behind;

   assign e      = $signed({18'd0, eps, 30'd0});
   assign flip   = ds8_ff > e;
   assign behind = ds8_ff < -e;
   assign dpo    = flip ? -dp8_ff : dp8_ff;

   always_comb begin
      line9_in.use_line = geo8_ff.ok && (flip || behind) && (dpo > e);
      line9_in.vert     = geo8_ff.vert;
      line9_in.horz     = geo8_ff.horz;
      line9_in.hx       = flip ? -hx8_ff : hx8_ff;
      line9_in.hy       = flip ? -hy8_ff : hy8_ff;
      line9_in.off      = flip ? -off8_ff : off8_ff;
      line9_in.cx       = geo8_ff.px;
      line9_in.cy       = geo8_ff.py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= dx_v[LineDivSteps];
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo5_ff   <= geo5;
         seg5_ff   <= dy_pay[LineDivSteps];
         hx5_ff    <= hx5_in;
         hy5_ff    <= hy5_in;
         geo6_ff   <= geo5_ff;
         seg6_ff   <= seg5_ff;
         hx6_ff    <= hx5_ff;
         hy6_ff    <= hy5_ff;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         p4_ff     <= p4_in;
         p5_ff     <= p5_in;
         p6_ff     <= p6_in;
         geo7_ff   <= geo6_ff;
         seg7_ff   <= seg6_ff;
         hx7_ff    <= hx6_ff;
         hy7_ff    <= hy6_ff;
         off7_ff   <= p1_ff + p2_ff;
         sa7_ff    <= p3_ff + p4_ff;
         pa7_ff    <= p5_ff + p6_ff;
         geo8_ff   <= geo7_ff;
         seg8_ff   <= seg7_ff;
         hx8_ff    <= hx7_ff;
         hy8_ff    <= hy7_ff;
         off8_ff   <= off7_ff;
         ds8_ff    <= sa7_ff - off7_ff;
         dp8_ff    <= pa7_ff - off7_ff;
         seg9_ff   <= seg8_ff;
         line9_ff  <= line9_in;
      end
   end

   assign out_valid = v9_ff;
   assign out_line  = line9_ff;
   assign out_seg   = seg9_ff;

endmodule

// ===== design/spsc_clip.sv =====
// Clips the target segment of an item against its first pending separating line.
module spsc_clip
   import spsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic [15:0] eps,
   input  logic        in_valid,
   input  item_type    in_item,
   output logic        out_valid,
   output item_type    out_item
);

   localparam int unsigned IW = $bits(item_type);
   localparam int unsigned PW = $bits(cut_type) + IW;

   logic signed [63:0] e;

   assign e = $signed({18'd0, eps, 30'd0});

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   item_type it0_ff, it1_ff, it2_ff, it3_ff;
   logic signed [63:0] pa_ff, pb_ff, pc_ff, pd_ff, q0_ff, q1_ff, d0_ff, d1_ff;
   logic [63:0] a0_ff, s_ff, a0_in, a1_in;
   cut_type cut3_ff, cut3_in;
   item_type it3_in;
   line_type ln0, ln2;
   logic act, back, keep;

   assign ln0 = in_item.lines[0];
   assign ln2 = it2_ff.lines[0];

   assign act   = it2_ff.vis && ln2.use_line;
   assign back  = (d0_ff < e) && (d1_ff < e);
   assign keep  = (d0_ff >= -e) && (d1_ff >= -e);
   assign a0_in = d0_ff[63] ? 64'(-d0_ff) : 64'(d0_ff);
   assign a1_in = d1_ff[63] ? 64'(-d1_ff) : 64'(d1_ff);

   always_comb begin
      it3_in      = it2_ff;
      it3_in.vis  = it2_ff.vis && !(act && back);
      cut3_in.cut = act && !back && !keep;
      cut3_in.at0 = d0_ff < -e;
      cut3_in.a1z = (a1_in == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it0_ff  <= in_item;
         pa_ff   <= in_item.seg.ax * ln0.hx;
         pb_ff   <= in_item.seg.ay * ln0.hy;
         pc_ff   <= in_item.seg.bx * ln0.hx;
         pd_ff   <= in_item.seg.by * ln0.hy;
         it1_ff  <= it0_ff;
         q0_ff   <= pa_ff + pb_ff;
         q1_ff   <= pc_ff + pd_ff;
         it2_ff  <= it1_ff;
         d0_ff   <= q0_ff - it1_ff.lines[0].off;
         d1_ff   <= q1_ff - it1_ff.lines[0].off;
         it3_ff  <= it3_in;
         cut3_ff <= cut3_in;
         a0_ff   <= a0_in;
         s_ff    <= a0_in + a1_in;
      end
   end

   logic          dv   [0:CutDivSteps];
   logic [63:0]   drem [0:CutDivSteps];
   logic [63:0]   ddiv [0:CutDivSteps];
   logic [31:0]   dq   [0:CutDivSteps];
   logic [PW-1:0] dpay [0:CutDivSteps];

   assign dv[0]   = v3_ff;
   assign drem[0] = a0_ff;
   assign ddiv[0] = s_ff;
   assign dq[0]   = 32'd0;
   assign dpay[0] = {cut3_ff, it3_ff};

   for (genvar k = 0; k < CutDivSteps; k++) begin : g_div
      spsc_div_cell #(.W(64), .QW(32), .PW(PW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv[k]),
         .in_rem    (drem[k]),
         .in_div    (ddiv[k]),
         .in_q      (dq[k]),
         .in_pay    (dpay[k]),
         .out_valid (dv[k+1]),
         .out_rem   (drem[k+1]),
         .out_div   (ddiv[k+1]),
         .out_q     (dq[k+1]),
         .out_pay   (dpay[k+1])
      );
   end

   cut_type            cut4;
   item_type           it4;
   logic [32:0]        t4, mgx4, mgy4;
   logic signed [32:0] dx4, dy4;

   assign {cut4, it4} = dpay[CutDivSteps];
   assign t4   = cut4.a1z ? 33'h1_0000_0000 : {1'b0, dq[CutDivSteps]};
   assign dx4  = 33'(it4.seg.bx) - 33'(it4.seg.ax);
   assign dy4  = 33'(it4.seg.by) - 33'(it4.seg.ay);
   assign mgx4 = dx4[32] ? 33'(-dx4) : 33'(dx4);
   assign mgy4 = dy4[32] ? 33'(-dy4) : 33'(dy4);

   logic        v5_ff, v6_ff;
   cut_type     cut5_ff;
   item_type    it5_ff, it6_ff, it6_in;
   logic [32:0] t5_ff;
   logic [64:0] prx5_ff, pry5_ff;
   logic        hbx5_ff, hby5_ff, ngx5_ff, ngy5_ff;
   logic [33:0] ox5, oy5, rx5, ry5;
   line_type    ln5;

   assign ln5 = it5_ff.lines[0];
   assign ox5 = 34'(hbx5_ff ? t5_ff : 33'd0) + 34'(prx5_ff[64:32]);
   assign oy5 = 34'(hby5_ff ? t5_ff : 33'd0) + 34'(pry5_ff[64:32]);
   assign rx5 = ngx5_ff ? 34'(it5_ff.seg.ax) - ox5 : 34'(it5_ff.seg.ax) + ox5;
   assign ry5 = ngy5_ff ? 34'(it5_ff.seg.ay) - oy5 : 34'(it5_ff.seg.ay) + oy5;

   always_comb begin
      logic signed [31:0] mx, my;
      mx     = ln5.vert ? ln5.cx : $signed(rx5[31:0]);
      my     = ln5.horz ? ln5.cy : $signed(ry5[31:0]);
      it6_in = it5_ff;
      if (cut5_ff.cut) begin
         if (cut5_ff.at0) begin
            it6_in.seg.ax = mx;
            it6_in.seg.ay = my;
         end else begin
            it6_in.seg.bx = mx;
            it6_in.seg.by = my;
         end
      end
      it6_in.lines = {it5_ff.lines[0], it5_ff.lines[NumLines-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= dv[CutDivSteps];
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it5_ff  <= it4;
         cut5_ff <= cut4;
         t5_ff   <= t4;
         prx5_ff <= mgx4[31:0] * t4;
         pry5_ff <= mgy4[31:0] * t4;
         hbx5_ff <= mgx4[32];
         hby5_ff <= mgy4[32];
         ngx5_ff <= dx4[32];
         ngy5_ff <= dy4[32];
         it6_ff  <= it6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_item  = it6_ff;

endmodule

// ===== tb/sv/tb_separator_plane_segment_clip_core.sv =====
// Self-checking testbench for the separator-line segment clip core.
`timescale 1ns / 100ps

module tb_separator_plane_segment_clip_core;
   import spsc_pkg::*;

   typedef longint unsigned u64_type;

   typedef struct packed {
      seg_type src;
      seg_type pas;
      seg_type tgt;
   } triple_type;

   typedef struct packed {
      logic    vis;
      seg_type seg;
   } clip_res_type;

   typedef struct {
      triple_type   stim;
      bit           known;
      clip_res_type want;
   } dir_row_type;

   typedef struct {
      longint hx, hy, off;
      bit     vert, horz;
      longint cx, cy;
   } cut_line_type;

   localparam int          Unit       = 65536;
   localparam int          CycleLimit = 400000;
   localparam int          HoldCycles = 700;
   localparam int          DrainWait  = 240;
   localparam logic [31:0] MaxV       = 32'h7fffffff;
   localparam logic [31:0] MinV       = 32'h80000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   triple_type   req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic         rsp_visible;
   logic [31:0]  rsp_out_ax, rsp_out_ay, rsp_out_bx, rsp_out_by;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_epsilon = '0;

   logic [15:0]  eps_model = EpsReset;
   clip_res_type clip_expect_q[$];
   dir_row_type  dir_rows[$];
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   bit           hold_req = 0;
   int           hold_left = 0;
   int           mismatches = 0;
   int           cycles = 0;

   separator_plane_segment_clip_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_src_ax  (req_item.src.ax),
      .req_src_ay  (req_item.src.ay),
      .req_src_bx  (req_item.src.bx),
      .req_src_by  (req_item.src.by),
      .req_pass_ax (req_item.pas.ax),
      .req_pass_ay (req_item.pas.ay),
      .req_pass_bx (req_item.pas.bx),
      .req_pass_by (req_item.pas.by),
      .req_tgt_ax  (req_item.tgt.ax),
      .req_tgt_ay  (req_item.tgt.ay),
      .req_tgt_bx  (req_item.tgt.bx),
      .req_tgt_by  (req_item.tgt.by),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_visible (rsp_visible),
      .rsp_out_ax  (rsp_out_ax),
      .rsp_out_ay  (rsp_out_ay),
      .rsp_out_bx  (rsp_out_bx),
      .rsp_out_by  (rsp_out_by),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_epsilon (csr_epsilon)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic u64_type mag(longint v);
      return (v < 0) ? 64'd0 - u64_type'(v) : u64_type'(v);
   endfunction

   function automatic u64_type int_sqrt(u64_type s);
      u64_type r, b;
      r = 0;
      b = u64_type'(1) << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint line_dist(cut_line_type ln, longint x, longint y);
      return x * ln.hx + y * ln.hy - ln.off;
   endfunction

   function automatic longint lerp(longint a, longint b, u64_type t);
      longint  diff;
      u64_type m, h, l, o;
      diff = b - a;
      m = mag(diff);
      h = m >> 32;
      l = m & 64'hFFFFFFFF;
      o = h * t + ((l * t) >> 32);
      return (diff < 0) ? a - longint'(o) : a + longint'(o);
   endfunction

   function automatic bit build_line(longint s_x, longint s_y, longint p_x, longint p_y,
                                     output cut_line_type ln);
      longint  nx, ny;
      u64_type ax, ay, m, r;
      nx = s_y - p_y;
      ny = p_x - s_x;
      ax = mag(nx);
      ay = mag(ny);
      ln = '{default: 0};
      if (ax == 0 && ay == 0) return 0;
      if (ax < 65536 && ay < 65536 && ax * ax + ay * ay < (u64_type'(eps_model) << 16))
         return 0;
      m = (ax > ay) ? ax : ay;
      while (m >= (u64_type'(1) << 31)) begin
         ax >>= 1;
         ay >>= 1;
         m >>= 1;
      end
      while (m < (u64_type'(1) << 30)) begin
         ax <<= 1;
         ay <<= 1;
         m <<= 1;
      end
      r = int_sqrt(ax * ax + ay * ay);
      ln.hx = longint'((ax << 30) / r);
      ln.hy = longint'((ay << 30) / r);
      if (nx < 0) ln.hx = -ln.hx;
      if (ny < 0) ln.hy = -ln.hy;
      ln.off = p_x * ln.hx + p_y * ln.hy;
      ln.vert = (ny == 0);
      ln.horz = (nx == 0);
      ln.cx = p_x;
      ln.cy = p_y;
      return 1;
   endfunction

   function automatic bit clip_target(cut_line_type ln, longint e,
                                      inout longint tx[2], inout longint ty[2]);
      longint  d0, d1, mx, my;
      u64_type a0, a1, s, rem, t;
      d0 = line_dist(ln, tx[0], ty[0]);
      d1 = line_dist(ln, tx[1], ty[1]);
      if (d0 < e && d1 < e) return 0;
      if (d0 >= -e && d1 >= -e) return 1;
      a0 = mag(d0);
      a1 = mag(d1);
      s = a0 + a1;
      t = 0;
      if (a1 == 0) begin
         t = u64_type'(1) << 32;
      end else begin
         rem = a0;
         for (int k = 0; k < 32; k++) begin
            if (rem >= s - rem) begin
               t = (t << 1) | 1;
               rem = rem - (s - rem);
            end else begin
               t <<= 1;
               rem = rem + rem;
            end
         end
      end
      mx = ln.vert ? ln.cx : lerp(tx[0], tx[1], t);
      my = ln.horz ? ln.cy : lerp(ty[0], ty[1], t);
      if (d0 < -e) begin
         tx[0] = mx;
         ty[0] = my;
      end else begin
         tx[1] = mx;
         ty[1] = my;
      end
      return 1;
   endfunction

   function automatic clip_res_type clip_predict(triple_type it);
      longint       sx[2], sy[2], px[2], py[2], tx[2], ty[2];
      longint       e, d;
      cut_line_type ln;
      bit           vis;
      clip_res_type r;
      sx = '{longint'(it.src.ax), longint'(it.src.bx)};
      sy = '{longint'(it.src.ay), longint'(it.src.by)};
      px = '{longint'(it.pas.ax), longint'(it.pas.bx)};
      py = '{longint'(it.pas.ay), longint'(it.pas.by)};
      tx = '{longint'(it.tgt.ax), longint'(it.tgt.bx)};
      ty = '{longint'(it.tgt.ay), longint'(it.tgt.by)};
      e = longint'(u64_type'(eps_model) << 30);
      vis = 1;
      for (int i = 0; i < 2 && vis; i++) begin
         for (int j = 0; j < 2 && vis; j++) begin
            if (!build_line(sx[i], sy[i], px[j], py[j], ln)) continue;
            d = line_dist(ln, sx[i ^ 1], sy[i ^ 1]);
            if (d > e) begin
               ln.hx = -ln.hx;
               ln.hy = -ln.hy;
               ln.off = -ln.off;
            end else if (d >= -e) begin
               continue;
            end
            if (line_dist(ln, px[j ^ 1], py[j ^ 1]) <= e) continue;
            if (!clip_target(ln, e, tx, ty)) vis = 0;
         end
      end
      r = '0;
      r.vis = vis;
      if (vis) begin
         r.seg.ax = tx[0][31:0];
         r.seg.ay = ty[0][31:0];
         r.seg.bx = tx[1][31:0];
         r.seg.by = ty[1][31:0];
      end
      return r;
   endfunction

   function automatic seg_type mk_seg(int ax, int ay, int bx, int by);
      seg_type s;
      s.ax = ax;
      s.ay = ay;
      s.bx = bx;
      s.by = by;
      return s;
   endfunction

   function automatic void add_row(seg_type s, seg_type p, seg_type t, bit known,
                                   clip_res_type want);
      dir_row_type row;
      row.stim.src = s;
      row.stim.pas = p;
      row.stim.tgt = t;
      row.known = known;
      row.want = want;
      dir_rows.push_back(row);
   endfunction

   function automatic clip_res_type kept(seg_type t);
      clip_res_type r;
      r.vis = 1'b1;
      r.seg = t;
      return r;
   endfunction

   function automatic void build_directed();
      int      u;
      seg_type s0, p0, xt, mm;
      u = Unit;
      s0 = mk_seg(-10 * u, -u, -10 * u, u);
      p0 = mk_seg(0, -u, 0, u);
      xt = mk_seg(MaxV, MinV, MinV, MaxV);
      mm = mk_seg(MaxV, MaxV, MinV, MinV);
      add_row('0, '0, '0, 1, kept('0));
      add_row(xt, xt, mm, 1, kept(mm));
      add_row(xt, xt, xt, 1, kept(xt));
      add_row({4{MaxV}}, {4{MaxV}}, {4{MaxV}}, 1, kept({4{MaxV}}));
      add_row({4{MinV}}, {4{MinV}}, {4{MinV}}, 1, kept({4{MinV}}));
      add_row({4{32'hffffffff}}, {4{32'hffffffff}}, {4{32'hffffffff}}, 1,
              kept({4{32'hffffffff}}));
      add_row(s0, p0, mk_seg(-20 * u, -u / 2, -20 * u, u / 2), 1, '0);
      add_row(s0, p0, mk_seg(10 * u, -u, 10 * u, u), 0, '0);
      add_row(s0, p0, mk_seg(10 * u, -20 * u, 10 * u, 20 * u), 0, '0);
      add_row(s0, p0, mk_seg(10 * u, 50 * u, 10 * u, 60 * u), 0, '0);
      add_row(s0, p0, mk_seg(-5 * u, -8 * u, 30 * u, 9 * u), 0, '0);
      add_row(mk_seg(0, -10 * u, 5 * u, -10 * u), mk_seg(0, 0, 5 * u, 0),
              mk_seg(-20 * u, 10 * u, 20 * u, 10 * u), 0, '0);
      add_row(mk_seg(-10 * u, 0, -10 * u, 5 * u), mk_seg(0, 0, 0, 5 * u),
              mk_seg(10 * u, -20 * u, 10 * u, 20 * u), 0, '0);
      add_row(s0, mk_seg(-10 * u + 100, -u, 0, u), mk_seg(10 * u, -u, 10 * u, u), 0, '0);
      add_row(s0, mk_seg(-10 * u + 30000, -u, 0, u), mk_seg(10 * u, -u, 10 * u, u), 0, '0);
      add_row(mk_seg(-10 * u, 0, -10 * u, 0), p0, mk_seg(10 * u, -u, 10 * u, u), 0, '0);
      add_row(s0, mk_seg(0, 0, 0, 0), mk_seg(10 * u, -u, 10 * u, u), 0, '0);
      add_row(mk_seg(MinV, -u, MinV, u), mk_seg(MaxV, -u, MaxV, u),
              mk_seg(MaxV, MinV, MaxV, MaxV), 0, '0);
      add_row(s0, p0, mk_seg(10 * u, -u, -20 * u, 0), 0, '0);
   endfunction

   function automatic int rnd_span(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic triple_type rand_triple();
      triple_type it;
      int         d, w, kind;
      seg_type    sg[3];
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         return it;
      end
      d = $urandom_range(1, 1 << $urandom_range(4, 28));
      w = $urandom_range(0, d);
      for (int k = 0; k < 3; k++) begin
         sg[k].ax = (k - 1) * d + rnd_span(w / 4);
         sg[k].ay = rnd_span(w);
         sg[k].bx = (k - 1) * d + rnd_span(w / 4);
         sg[k].by = rnd_span(w);
      end
      if (kind < 30) begin
         sg[1].ax = sg[0].ax + rnd_span($urandom_range(0, 3) * 200);
         sg[1].ay = sg[0].ay + rnd_span($urandom_range(0, 3) * 200);
      end else if (kind < 40) begin
         sg[1].bx = sg[0].bx;
         sg[1].ax = sg[0].ax;
      end else if (kind < 48) begin
         sg[1].ay = sg[0].ay;
         sg[1].by = sg[0].by;
      end else if (kind < 52) begin
         sg[0].bx = sg[0].ax;
         sg[0].by = sg[0].ay;
      end
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(0, 1)) sg[k] = {sg[k].ay, sg[k].ax, sg[k].by, sg[k].bx};
      end
      it.src = sg[0];
      it.pas = sg[1];
      it.tgt = sg[2];
      if ($urandom_range(0, 1)) it = {it.src.ay, it.src.ax, it.src.by, it.src.bx,
                                      it.pas.ay, it.pas.ax, it.pas.by, it.pas.bx,
                                      it.tgt.ay, it.tgt.ax, it.tgt.by, it.tgt.bx};
      if ($urandom_range(0, 1)) it = {-it.src.ax, it.src.ay, -it.src.bx, it.src.by,
                                      -it.pas.ax, it.pas.ay, -it.pas.bx, it.pas.by,
                                      -it.tgt.ax, it.tgt.ay, -it.tgt.bx, it.tgt.by};
      return it;
   endfunction

   task automatic offer_item(triple_type it, bit known, clip_res_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_item = it;
      do @(posedge clock); while (req_stall);
      clip_expect_q.push_back(known ? want : clip_predict(it));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (clip_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_epsilon(logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_epsilon = value;
      do @(posedge clock); while (!csr_ready);
      eps_model = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HoldCycles;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      clip_res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (clip_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
         end else begin
            want = clip_expect_q.pop_front();
            if (rsp_visible !== want.vis || rsp_out_ax !== want.seg.ax ||
                rsp_out_ay !== want.seg.ay || rsp_out_bx !== want.seg.bx ||
                rsp_out_by !== want.seg.by) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected vis %0b (%h %h %h %h), got %0b (%h %h %h %h)",
                           want.vis, want.seg.ax, want.seg.ay, want.seg.bx, want.seg.by,
                           rsp_visible, rsp_out_ax, rsp_out_ay, rsp_out_bx, rsp_out_by);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [15:0] eps_plan[5];
      int          send_plan[5];
      int          recv_plan[5];
      eps_plan = '{EpsReset, 16'd0, 16'hffff, 16'd1, 16'($urandom)};
      send_plan = '{0, 75, 0, 28, 0};
      recv_plan = '{0, 0, 75, 28, 0};
      build_directed();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) write_epsilon(eps_plan[ph]);
         send_idle_pct = send_plan[ph];
         recv_stall_pct = recv_plan[ph];
         if (ph == 0) begin
            foreach (dir_rows[k]) offer_item(dir_rows[k].stim, dir_rows[k].known,
                                             dir_rows[k].want);
         end
         if (ph == 2) hold_req = 1;
         for (int n = 0; n < 260; n++) begin
            if (ph == 3 && n == 130) wait_drained();
            offer_item(rand_triple(), 0, '0);
         end
      end
      wait_drained();
      repeat (DrainWait) @(posedge clock);
      if (mismatches == 0 && clip_expect_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/spsc_pkg.sv
design/spsc_sqrt_cell.sv
design/spsc_div_cell.sv
design/spsc_line.sv
design/spsc_clip.sv
design/separator_plane_segment_clip_core.sv
tb/sv/tb_separator_plane_segment_clip_core.sv
